// ===== rtl/mwss_pkg.sv =====
// ----------------------------------------------------------------------------
// mwss_pkg
// Shared widths, signature tables and inter-module types for the masked word
// signature scanner.
// ----------------------------------------------------------------------------
package mwss_pkg;

	localparam int GATES        = 3;
	localparam int SIG_MAX      = 5;
	localparam int WINDOW_DEPTH = 5;

	localparam int unsigned MAX_WORDS = 32'd16777216;
	localparam int SEEN_W = $clog2(MAX_WORDS + 1);

	localparam int WORD_W    = 32;
	localparam int POS_W     = 24;
	localparam int CNT_W     = 16;
	localparam int COND_W    = 4;
	localparam int GATE_W    = $clog2(GATES);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = COND_W;

	// result payload: count, unique flag, index, patched word, all-unique flag
	localparam int REP_BITS = CNT_W + 1 + POS_W + WORD_W + 1;
	localparam int TDATA_W  = ((REP_BITS + 7) / 8) * 8;
	localparam int PAD_W    = TDATA_W - REP_BITS;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [GATES-1:0][COND_W-1:0] cond_vec_t;

	localparam logic [GATE_W-1:0] LAST_GATE = GATE_W'(GATES - 1);
	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

	localparam logic [COND_W-1:0] COND_RESET [GATES] = '{4'd10, 4'd10, 4'd11};

	// signature k-th word is the oldest-first position inside the window
	localparam word_t SIG_VALUE [GATES][SIG_MAX] = '{
		'{32'hb9422800, 32'h7100081f, 32'h54000000, 32'h52800020, 32'h00000000},
		'{32'hb9422800, 32'h7100081f, 32'h54000000, 32'h71000c1f, 32'h54000000},
		'{32'hf940cc00, 32'hb9422800, 32'h7100081f, 32'h54000001, 32'hf9408400}
	};
	localparam word_t SIG_MASK [GATES][SIG_MAX] = '{
		'{32'hfffffc00, 32'hfffffc1f, 32'hff00001f, 32'hffffffe0, 32'h00000000},
		'{32'hfffffc00, 32'hfffffc1f, 32'hff00001f, 32'hfffffc1f, 32'hff000010},
		'{32'hfffffc00, 32'hfffffc00, 32'hfffffc1f, 32'hff00001f, 32'hfffffc00}
	};
	localparam int SIG_LEN    [GATES] = '{4, 5, 5};
	localparam int SIG_BRANCH [GATES] = '{2, 2, 3};

	typedef struct packed {
		logic [GATES-1:0]             hit;
		logic [GATES-1:0][POS_W-1:0]  pos;
		logic [GATES-1:0][WORD_W-1:0] bword;
	} match_t;

	typedef struct packed {
		logic [GATES-1:0][CNT_W-1:0]  count;
		logic [GATES-1:0][POS_W-1:0]  pos;
		logic [GATES-1:0][WORD_W-1:0] bword;
	} tally_t;

endpackage

// ===== rtl/mwss_matcher.sv =====
// ----------------------------------------------------------------------------
// mwss_matcher
// Word history window, word counter and parallel masked signature compares.
// ----------------------------------------------------------------------------
module mwss_matcher (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  mwss_pkg::word_t       word,
	input  logic                  last,
	output mwss_pkg::match_t      match
);

	mwss_pkg::word_t hist_q [mwss_pkg::WINDOW_DEPTH-1];
	mwss_pkg::word_t win_new [mwss_pkg::WINDOW_DEPTH];
	logic [mwss_pkg::SEEN_W-1:0] seen_q;
	logic scan_en;

	assign scan_en = (seen_q < mwss_pkg::SEEN_W'(mwss_pkg::MAX_WORDS));

	// index 0 is the newest word
	always_comb begin
		win_new[0] = word;
		for (int i = 1; i < mwss_pkg::WINDOW_DEPTH; i++) begin
			win_new[i] = hist_q[i-1];
		end
	end

	genvar g, k;
	generate
		for (g = 0; g < mwss_pkg::GATES; g++) begin : gen_gate
			logic [mwss_pkg::SIG_MAX-1:0] word_ok;
			logic full;
			for (k = 0; k < mwss_pkg::SIG_MAX; k++) begin : gen_word
				if (k < mwss_pkg::SIG_LEN[g]) begin : gen_cmp
					assign word_ok[k] =
						((win_new[mwss_pkg::SIG_LEN[g]-1-k] & mwss_pkg::SIG_MASK[g][k])
						 == mwss_pkg::SIG_VALUE[g][k]);
				end else begin : gen_pad
					assign word_ok[k] = 1'b1;
				end
			end
			assign full = (seen_q >= mwss_pkg::SEEN_W'(mwss_pkg::SIG_LEN[g] - 1));
			assign match.hit[g] = scan_en && full && (&word_ok);
			// branch index = this word's index minus distance back to branch word
			assign match.pos[g] = mwss_pkg::POS_W'(seen_q)
				- mwss_pkg::POS_W'(mwss_pkg::SIG_LEN[g] - 1 - mwss_pkg::SIG_BRANCH[g]);
			assign match.bword[g] =
				win_new[mwss_pkg::SIG_LEN[g] - 1 - mwss_pkg::SIG_BRANCH[g]];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (step) begin
			if (last) begin
				seen_q <= '0;
			end else if (scan_en) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	// window words are only compared once the counter says they were filled
	always_ff @(posedge clk) begin
		if (step && scan_en) begin
			for (int i = 0; i < mwss_pkg::WINDOW_DEPTH-1; i++) begin
				hist_q[i] <= win_new[i];
			end
		end
	end

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= mwss_pkg::SEEN_W'(mwss_pkg::MAX_WORDS))
		else $error("word counter ran past the region limit");

endmodule

// ===== rtl/mwss_tally.sv =====
// ----------------------------------------------------------------------------
// mwss_tally
// Per-gate saturating match counters with latest branch index and word.
// ----------------------------------------------------------------------------
module mwss_tally (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              last,
	input  mwss_pkg::match_t  match,
	output mwss_pkg::tally_t  snap
);

	mwss_pkg::tally_t tally_q;

	// snap is the state after the current word is scanned
	always_comb begin
		snap = tally_q;
		for (int g = 0; g < mwss_pkg::GATES; g++) begin
			if (match.hit[g]) begin
				if (tally_q.count[g] != mwss_pkg::COUNT_MAX) begin
					snap.count[g] = tally_q.count[g] + 1'b1;
				end
				snap.pos[g]   = match.pos[g];
				snap.bword[g] = match.bword[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (step) begin
			if (last) begin
				tally_q <= '0;
			end else begin
				tally_q <= snap;
			end
		end
	end

endmodule

// ===== rtl/mwss_report.sv =====
// ----------------------------------------------------------------------------
// mwss_report
// Report buffer: captures the three gate results at region end and sends
// them out one per request.
// ----------------------------------------------------------------------------
module mwss_report (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  mwss_pkg::tally_t                    snap,
	input  mwss_pkg::cond_vec_t                 cond,
	output logic                                free,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mwss_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic [mwss_pkg::GATE_W-1:0]         m_axis_tuser,
	output logic                                m_axis_tlast
);

	logic [mwss_pkg::GATES-1:0][mwss_pkg::CNT_W-1:0]  count_q;
	logic [mwss_pkg::GATES-1:0][mwss_pkg::POS_W-1:0]  pos_q;
	logic [mwss_pkg::GATES-1:0][mwss_pkg::WORD_W-1:0] patched_q;
	logic                                              all_q;
	logic                                              busy_q;
	logic [mwss_pkg::GATE_W-1:0]                       idx_q;

	logic [mwss_pkg::GATES-1:0][mwss_pkg::POS_W-1:0]  pos_d;
	logic [mwss_pkg::GATES-1:0][mwss_pkg::WORD_W-1:0] patched_d;
	logic all_d;
	logic out_fire;
	logic uniq;

	always_comb begin
		all_d = 1'b1;
		for (int g = 0; g < mwss_pkg::GATES; g++) begin
			if (snap.count[g] != mwss_pkg::CNT_W'(1)) begin
				all_d = 1'b0;
			end
			if (snap.count[g] == '0) begin
				pos_d[g]     = '0;
				patched_d[g] = '0;
			end else begin
				pos_d[g]     = snap.pos[g];
				patched_d[g] = {snap.bword[g][mwss_pkg::WORD_W-1:mwss_pkg::COND_W], cond[g]};
			end
		end
	end

	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign free     = !busy_q || (out_fire && idx_q == mwss_pkg::LAST_GATE);

	assign m_axis_tvalid = busy_q;
	assign m_axis_tuser  = idx_q;
	assign m_axis_tlast  = (idx_q == mwss_pkg::LAST_GATE);
	assign uniq          = (count_q[idx_q] == mwss_pkg::CNT_W'(1));
	// fields from bit 0: match_count, unique_match, branch_word_index,
	// patched_instruction, all_unique, zero pad
	assign m_axis_tdata  = {{mwss_pkg::PAD_W{1'b0}}, all_q, patched_q[idx_q],
		pos_q[idx_q], uniq, count_q[idx_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (idx_q == mwss_pkg::LAST_GATE) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			count_q   <= snap.count;
			pos_q     <= pos_d;
			patched_q <= patched_d;
			all_q     <= all_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!busy_q || (out_fire && idx_q == mwss_pkg::LAST_GATE)))
		else $error("report buffer reloaded while reports were pending");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= mwss_pkg::LAST_GATE))
		else $error("report index out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && idx_q == mwss_pkg::LAST_GATE && !load) |=> !busy_q)
		else $error("report buffer did not empty after third report");

endmodule

// ===== rtl/masked_word_signature_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// masked_word_signature_scanner_unit
// Scans an instruction word stream for three masked signatures and reports
// per-gate counts and patched branch words at each region end.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 content
//  s_axis    in   tvalid/tready             one instruction word, tlast = region end
//  m_axis    out  tvalid/tready             one gate report, tuser = gate, tlast = third
//  cfg       in   cfg_we                    branch condition per gate
//
//  one word per cycle unless a region end waits; a region end passes the input
//  register, then compare/count into the report buffer once it is free
//  a region end gives three reports from the buffer, one per unstalled cycle;
//  a later region end waits in the input register until the buffer drains
//  arst_n clears counters, window fill count and report buffer, and loads
//  the condition registers with 10, 10, 11
//  output stalls hold back the input only when a region end is waiting
module masked_word_signature_scanner_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [mwss_pkg::WORD_W-1:0]          s_axis_tdata,  // instruction_word
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// match_count, unique_match, branch_word_index, patched_instruction,
	// all_unique, zero pad
	output logic [mwss_pkg::TDATA_W-1:0]         m_axis_tdata,
	output logic [mwss_pkg::GATE_W-1:0]          m_axis_tuser,  // gate_number
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_we,
	input  logic [mwss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mwss_pkg::CFG_W-1:0]           cfg_wdata
);

	mwss_pkg::word_t     word_s1;
	logic                last_s1;
	logic                valid_s1;
	logic                step;
	logic                rep_free;
	mwss_pkg::cond_vec_t cond_q;
	mwss_pkg::match_t    match;
	mwss_pkg::tally_t    snap;

	// a region end may only move on when the report buffer can take it
	assign step          = valid_s1 && (!last_s1 || rep_free);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < mwss_pkg::GATES; g++) begin
				cond_q[g] <= mwss_pkg::COND_RESET[g];
			end
		end else if (cfg_we && (cfg_index < mwss_pkg::CFG_IDX_W'(mwss_pkg::GATES))) begin
			cond_q[cfg_index] <= cfg_wdata;
		end
	end

	mwss_matcher u_matcher (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (word_s1),
		.last   (last_s1),
		.match  (match)
	);

	mwss_tally u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.last   (last_s1),
		.match  (match),
		.snap   (snap)
	);

	mwss_report u_report (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && last_s1),
		.snap          (snap),
		.cond          (cond_q),
		.free          (rep_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== test/masked_word_signature_scanner_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_word_signature_scanner_checker
// Watches the word and report streams of the scanner, keeps its own model of
// the signature window and per-gate tallies, and compares every report field
// by field against the oldest predicted report.
// ----------------------------------------------------------------------------
module masked_word_signature_scanner_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [mwss_pkg::WORD_W-1:0]    s_axis_tdata,  // instruction_word
	input  logic                           s_axis_tlast,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// match_count, unique_match, branch_word_index, patched_instruction,
	// all_unique, zero pad
	input  logic [mwss_pkg::TDATA_W-1:0]   m_axis_tdata,
	input  logic [mwss_pkg::GATE_W-1:0]    m_axis_tuser,  // gate_number
	input  logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic [mwss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwss_pkg::CFG_W-1:0]     cfg_wdata,
	output int                             mismatches,
	output int                             reports_due
);

	localparam int NGATES     = 3;
	localparam int WIN_DEPTH  = 5;
	localparam int SCAN_LIMIT = 16777216;

	// signature words, oldest first
	localparam logic [31:0] GATE_VALUE [NGATES][WIN_DEPTH] = '{
		'{32'hb9422800, 32'h7100081f, 32'h54000000, 32'h52800020, 32'h00000000},
		'{32'hb9422800, 32'h7100081f, 32'h54000000, 32'h71000c1f, 32'h54000000},
		'{32'hf940cc00, 32'hb9422800, 32'h7100081f, 32'h54000001, 32'hf9408400}
	};
	localparam logic [31:0] GATE_MASK [NGATES][WIN_DEPTH] = '{
		'{32'hfffffc00, 32'hfffffc1f, 32'hff00001f, 32'hffffffe0, 32'h00000000},
		'{32'hfffffc00, 32'hfffffc1f, 32'hff00001f, 32'hfffffc1f, 32'hff000010},
		'{32'hfffffc00, 32'hfffffc00, 32'hfffffc1f, 32'hff00001f, 32'hfffffc00}
	};
	localparam int GATE_LEN    [NGATES] = '{4, 5, 5};
	localparam int GATE_BRANCH [NGATES] = '{2, 2, 3};
	localparam logic [3:0] COND_AT_RESET [NGATES] = '{4'd10, 4'd10, 4'd11};

	typedef struct packed {
		logic [1:0]  gate;
		logic [15:0] count;
		logic        unique_hit;
		logic [23:0] branch_pos;
		logic [31:0] patched;
		logic        all_once;
		logic        last_gate;
	} gate_report_t;

	logic [31:0]  window [WIN_DEPTH];  // index 0 is the newest word
	int unsigned  words_in_region;
	logic [15:0]  hit_count [NGATES];
	logic [23:0]  hit_branch_pos [NGATES];
	logic [31:0]  hit_branch_word [NGATES];
	logic [3:0]   branch_cond [NGATES];
	gate_report_t reports_expected [$];

	initial mismatches = 0;

	task automatic clear_region();
		for (int i = 0; i < WIN_DEPTH; i++)
			window[i] = '0;
		words_in_region = 0;
		for (int g = 0; g < NGATES; g++) begin
			hit_count[g]       = '0;
			hit_branch_pos[g]  = '0;
			hit_branch_word[g] = '0;
		end
	endtask

	task automatic scan_word(input logic [31:0] word, input logic region_end);
		logic         matched;
		logic         all_once;
		int unsigned  idx;
		gate_report_t rep;
		// words past the scan limit are dropped, the end mark still counts
		if (words_in_region < SCAN_LIMIT) begin
			idx = words_in_region;
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = word;
			words_in_region = idx + 1;
			for (int g = 0; g < NGATES; g++) begin
				matched = (words_in_region >= GATE_LEN[g]);
				for (int k = 0; k < GATE_LEN[g]; k++)
					if ((window[GATE_LEN[g]-1-k] & GATE_MASK[g][k]) != GATE_VALUE[g][k])
						matched = 1'b0;
				if (matched) begin
					if (hit_count[g] != 16'hffff)
						hit_count[g] = hit_count[g] + 16'd1;
					hit_branch_pos[g]  = 24'(idx + 1 - GATE_LEN[g] + GATE_BRANCH[g]);
					hit_branch_word[g] = window[GATE_LEN[g]-1-GATE_BRANCH[g]];
				end
			end
		end
		if (region_end) begin
			all_once = 1'b1;
			for (int g = 0; g < NGATES; g++)
				if (hit_count[g] != 16'd1)
					all_once = 1'b0;
			for (int g = 0; g < NGATES; g++) begin
				rep.gate       = 2'(g);
				rep.count      = hit_count[g];
				rep.unique_hit = (hit_count[g] == 16'd1);
				if (hit_count[g] != 16'd0) begin
					rep.branch_pos = hit_branch_pos[g];
					rep.patched    = {hit_branch_word[g][31:4], branch_cond[g]};
				end else begin
					rep.branch_pos = '0;
					rep.patched    = '0;
				end
				rep.all_once  = all_once;
				rep.last_gate = (g == NGATES - 1);
				reports_expected.push_back(rep);
			end
			clear_region();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_report();
		gate_report_t want;
		if (reports_expected.size() == 0) begin
			$display("%0t: report for gate %0d arrived with none expected, actual %h",
				$time, m_axis_tuser, m_axis_tdata);
			mismatches++;
		end else begin
			want = reports_expected.pop_front();
			check_field("gate_number", 32'(want.gate), 32'(m_axis_tuser));
			check_field("match_count", 32'(want.count), 32'(m_axis_tdata[15:0]));
			check_field("unique_match", 32'(want.unique_hit), 32'(m_axis_tdata[16]));
			check_field("branch_word_index", 32'(want.branch_pos), 32'(m_axis_tdata[40:17]));
			check_field("patched_instruction", want.patched, m_axis_tdata[72:41]);
			check_field("all_unique", 32'(want.all_once), 32'(m_axis_tdata[73]));
			check_field("report_last", 32'(want.last_gate), 32'(m_axis_tlast));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_region();
			for (int g = 0; g < NGATES; g++)
				branch_cond[g] = COND_AT_RESET[g];
			reports_expected.delete();
		end else begin
			if (cfg_we && cfg_index < NGATES)
				branch_cond[cfg_index] = cfg_wdata;
			// reports leaving now always belong to an earlier region
			if (m_axis_tvalid && m_axis_tready)
				compare_report();
			if (s_axis_tvalid && s_axis_tready)
				scan_word(s_axis_tdata, s_axis_tlast);
		end
		reports_due = reports_expected.size();
	end

endmodule

// ===== test/tb_masked_word_signature_scanner_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_word_signature_scanner_unit
// Drives instruction word regions into the scanner: directed signature hits,
// a burst of repeated gate hits with no idling, a long output stall and random
// regions built from whole, spoiled and noise signatures, with condition
// register changes between phases. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_masked_word_signature_scanner_unit;

	localparam int CLK_PERIOD    = 12;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_WORDS  = 180;
	localparam int BURST_REPEATS = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_PERCENT  = 8;
	localparam int DRAIN_CYCLES  = 8;

	localparam logic [mwss_pkg::CFG_IDX_W-1:0] GATE0_COND_REG = 2'd0;
	localparam logic [mwss_pkg::CFG_IDX_W-1:0] GATE1_COND_REG = 2'd1;
	localparam logic [mwss_pkg::CFG_IDX_W-1:0] GATE2_COND_REG = 2'd2;
	localparam logic [mwss_pkg::CFG_IDX_W-1:0] UNUSED_REG     = 2'd3;

	typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [mwss_pkg::WORD_W-1:0]    s_axis_tdata;
	logic                           s_axis_tlast;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [mwss_pkg::TDATA_W-1:0]   m_axis_tdata;
	logic [mwss_pkg::GATE_W-1:0]    m_axis_tuser;
	logic                           m_axis_tlast;
	logic                           cfg_we;
	logic [mwss_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mwss_pkg::CFG_W-1:0]     cfg_wdata;

	int mismatches;
	int reports_due;
	int words_sent;
	int cycle_count;
	bit no_idle;
	bit hold_req;

	masked_word_signature_scanner_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	masked_word_signature_scanner_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.reports_due   (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_masked_word_signature_scanner_unit: done, errors");
		$finish;
	end

	// report side: random stalls, one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	task automatic send_word(input mwss_pkg::word_t word, input logic region_end);
		if (!no_idle)
			while ($urandom_range(99) < IDLE_PERCENT) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tlast  <= region_end;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	function automatic mwss_pkg::word_t pattern_word(input int g, input int k,
			input mwss_pkg::word_t filler);
		return (mwss_pkg::SIG_VALUE[g][k] & mwss_pkg::SIG_MASK[g][k])
			| (filler & ~mwss_pkg::SIG_MASK[g][k]);
	endfunction

	// one signature, optionally spoiled by flipping a single compared bit
	task automatic send_gate(input int g, input fill_t fill, input logic region_end,
			input bit spoil);
		int              bad_word;
		int              bad_bit;
		mwss_pkg::word_t filler;
		mwss_pkg::word_t word;
		bad_word = $urandom_range(mwss_pkg::SIG_LEN[g] - 1);
		do
			bad_bit = $urandom_range(mwss_pkg::WORD_W - 1);
		while (!mwss_pkg::SIG_MASK[g][bad_word][bad_bit]);
		for (int k = 0; k < mwss_pkg::SIG_LEN[g]; k++) begin
			case (fill)
				FILL_ZERO: filler = '0;
				FILL_ONES: filler = '1;
				default:   filler = $urandom;
			endcase
			word = pattern_word(g, k, filler);
			if (spoil && k == bad_word)
				word[bad_bit] = ~word[bad_bit];
			send_word(word, region_end && (k == mwss_pkg::SIG_LEN[g] - 1));
		end
	endtask

	task automatic send_noise(input int count, input logic region_end);
		for (int i = 0; i < count; i++)
			send_word($urandom, region_end && (i == count - 1));
	endtask

	task automatic send_random_region();
		int chunks;
		int pick;
		logic fin;
		chunks = $urandom_range(5, 1);
		for (int c = 0; c < chunks; c++) begin
			fin  = (c == chunks - 1);
			pick = $urandom_range(99);
			if (pick < 60)
				send_gate($urandom_range(mwss_pkg::GATES - 1), FILL_RANDOM, fin, 1'b0);
			else if (pick < 75)
				send_gate($urandom_range(mwss_pkg::GATES - 1), FILL_RANDOM, fin, 1'b1);
			else
				send_noise($urandom_range(4, 1), fin);
		end
	endtask

	// drop the request line and let the block run dry before touching registers
	task automatic wait_reports_done();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (reports_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [mwss_pkg::CFG_IDX_W-1:0] index,
			input logic [mwss_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic apply_conditions(input logic [mwss_pkg::CFG_W-1:0] c0,
			input logic [mwss_pkg::CFG_W-1:0] c1, input logic [mwss_pkg::CFG_W-1:0] c2,
			input bit with_unused);
		write_reg(GATE0_COND_REG, c0);
		write_reg(GATE1_COND_REG, c1);
		write_reg(GATE2_COND_REG, c2);
		if (with_unused)
			write_reg(UNUSED_REG, mwss_pkg::CFG_W'($urandom_range(15)));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int region_count;
		int first_random;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		no_idle       = 1'b0;
		hold_req      = 1'b0;
		words_sent    = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one-word regions, then a hit on the very first full window,
		// then every gate exactly once under the reset conditions
		send_word('1, 1'b1);
		send_word('0, 1'b1);
		send_gate(2, FILL_ZERO, 1'b1, 1'b0);
		send_gate(1, FILL_ONES, 1'b0, 1'b0);
		send_gate(0, FILL_ONES, 1'b0, 1'b0);
		send_gate(2, FILL_ONES, 1'b1, 1'b0);
		wait_reports_done();

		// back-to-back gate 0 hits with no idling, later hits still move the branch
		apply_conditions(4'd0, 4'd15, 4'd5, 1'b1);
		no_idle = 1'b1;
		for (int r = 0; r < BURST_REPEATS; r++)
			send_gate(0, FILL_RANDOM, r == BURST_REPEATS - 1, 1'b0);
		no_idle = 1'b0;
		wait_reports_done();

		// reports back up behind a long stall until the input is held off
		apply_conditions(4'd15, 4'd0, 4'd15, 1'b0);
		hold_req = 1'b1;
		for (int r = 0; r < 8; r++)
			send_random_region();
		wait_reports_done();

		apply_conditions(mwss_pkg::CFG_W'($urandom_range(15)),
			mwss_pkg::CFG_W'($urandom_range(15)), mwss_pkg::CFG_W'($urandom_range(15)), 1'b0);
		region_count = 0;
		first_random = words_sent;
		while (words_sent - first_random < RANDOM_WORDS) begin
			send_random_region();
			region_count++;
			if (region_count % 6 == 0) begin
				wait_reports_done();
				apply_conditions(mwss_pkg::CFG_W'($urandom_range(15)),
					mwss_pkg::CFG_W'($urandom_range(15)),
					mwss_pkg::CFG_W'($urandom_range(15)), $urandom_range(3) == 0);
			end
		end
		wait_reports_done();

		if (mismatches == 0 && reports_due == 0)
			$display("tb_masked_word_signature_scanner_unit: done, clean");
		else
			$display("tb_masked_word_signature_scanner_unit: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mwss_pkg.sv
rtl/mwss_matcher.sv
rtl/mwss_tally.sv
rtl/mwss_report.sv
rtl/masked_word_signature_scanner_unit.sv
test/masked_word_signature_scanner_checker.sv
test/tb_masked_word_signature_scanner_unit.sv
